[sv/kmer_pkg.sv]
// Shared constants, types and width helpers for the key matrix event block.
// Used by the top level, kmer_front and kmer_back; has no dependencies of its own.
`default_nettype none

package kmer_pkg;

    localparam int ROWS_DEF    = 4;
    localparam int COLS_DEF    = 14;
    localparam int KEY_W       = 56;
    localparam int TIME_W      = 32;
    localparam int LIMIT_W     = 6;
    localparam int MS_W        = 16;
    localparam int MAX_EVENTS  = 13;
    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 56;
    localparam int IN_DATA_W   = 88;
    localparam int OUT_DATA_W  = 8;
    localparam int OUT_USER_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_PRESENT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GHOST    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd6;

    typedef struct packed {
        logic [KEY_W-1:0]   present_mask;
        logic [KEY_W-1:0]   repeat_mask;
        logic [KEY_W-1:0]   release_mask;
        logic [LIMIT_W-1:0] ghost_limit;
        logic [MS_W-1:0]    scan_interval;
        logic [MS_W-1:0]    repeat_delay;
        logic [MS_W-1:0]    repeat_period;
    } t_cfg;

    typedef struct packed {
        logic       last;
        logic       is_combo;
        logic       is_repeat;
        logic       is_down;
        logic [3:0] key_col;
        logic [1:0] key_row;
    } t_event;

    // Bits needed to index n entries, at least one.
    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // Job word: press bits, release bits, repeat column, repeat row,
    // repeat flag and combo flag, lowest first.
    function automatic int job_w(input int rows, input int cols);
        return 2 * rows * cols + idx_w(cols) + idx_w(rows) + 2;
    endfunction

endpackage

`default_nettype wire

[sv/key_matrix_edge_repeat_core.sv]
// Key matrix scanner with edge events and auto-repeat: top level.
// Holds the configuration registers and joins kmer_front, kmer_fifo, kmer_back.
//
// Input stream: one word per matrix snapshot, tdata = snapshot[55:0] (bit
// row*COLS+col set for a key down) and now_ms[87:56]. A snapshot taken within
// scan_interval ms of the last taken one is accepted and dropped. A taken
// snapshot goes through capture, row counts and classification, which waits
// while the job queue is full; no new input word is taken until it is done.
// Output stream: one word per key event, up to 13 per snapshot, tlast on the
// final one. The back end loads a job from the queue and then sends one event
// per cycle while the receiver takes them.
// A two-entry job queue lets the front classify the next snapshot while the
// back still drains the previous one; when the receiver stalls, the output
// register holds its word, the queue fills and then the input stops taking.
// Configuration writes are always accepted and belong only to idle periods.
// Reset (synchronous, active low) restores the register defaults, clears the
// held keys, the repeat state and the last-taken time, and empties the queue.
`default_nettype none

module key_matrix_edge_repeat_core #(
    parameter int ROWS = kmer_pkg::ROWS_DEF,
    parameter int COLS = kmer_pkg::COLS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [kmer_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [kmer_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // snapshot [55:0], now_ms [87:56]
    input  wire logic [kmer_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // key_row [1:0], key_col [5:2], zero [7:6]
    output logic [kmer_pkg::OUT_DATA_W-1:0]          o_m_axis_tdata,
    // is_down [0], is_repeat [1], is_combo [2]
    output logic [kmer_pkg::OUT_USER_W-1:0]          o_m_axis_tuser,
    output logic                                     o_m_axis_tlast
);
    import kmer_pkg::*;

    localparam int JOB_W = job_w(ROWS, COLS);

    t_cfg             r_cfg;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    logic [JOB_W-1:0] job_in;
    logic [JOB_W-1:0] job_out;
    t_event           ev;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.present_mask  <= '1;
            r_cfg.repeat_mask   <= '0;
            r_cfg.release_mask  <= '0;
            r_cfg.ghost_limit   <= LIMIT_W'(6);
            r_cfg.scan_interval <= MS_W'(15);
            r_cfg.repeat_delay  <= MS_W'(420);
            r_cfg.repeat_period <= MS_W'(120);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PRESENT:  r_cfg.present_mask  <= i_cfg_data[KEY_W-1:0];
                REG_REPEAT:   r_cfg.repeat_mask   <= i_cfg_data[KEY_W-1:0];
                REG_RELEASE:  r_cfg.release_mask  <= i_cfg_data[KEY_W-1:0];
                REG_GHOST:    r_cfg.ghost_limit   <= i_cfg_data[LIMIT_W-1:0];
                REG_INTERVAL: r_cfg.scan_interval <= i_cfg_data[MS_W-1:0];
                REG_DELAY:    r_cfg.repeat_delay  <= i_cfg_data[MS_W-1:0];
                REG_PERIOD:   r_cfg.repeat_period <= i_cfg_data[MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    kmer_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_snapshot (i_s_axis_tdata[KEY_W-1:0]),
        .i_now      (i_s_axis_tdata[KEY_W +: TIME_W]),
        .o_push     (push),
        .o_job      (job_in),
        .i_full     (full)
    );

    kmer_fifo #(
        .W     (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_empty (empty)
    );

    kmer_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (job_out),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_event (ev)
    );

    assign o_m_axis_tdata = {2'b00, ev.key_col, ev.key_row};
    assign o_m_axis_tuser = {ev.is_combo, ev.is_repeat, ev.is_down};
    assign o_m_axis_tlast = ev.last;

    // A stalled output word stays as it is until the receiver takes it.
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("output word changed while stalled");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && full))
        else $error("job pushed into a full queue");

    a_repeat_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |-> o_m_axis_tuser[0] && !o_m_axis_tuser[2])
        else $error("repeat event without press flag or with combo flag");

    a_combo_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[2] |->
            o_m_axis_tuser[0] && o_m_axis_tdata[1:0] == 2'd1 && o_m_axis_tdata[5:2] == 4'd0)
        else $error("combo flag on an event other than its own key press");

endmodule

`default_nettype wire

[sv/kmer_fifo.sv]
// Small flip-flop queue carrying classified jobs from the front to the back.
// Stand-alone; the word width and depth come from the instantiating level.
`default_nettype none

module kmer_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[sv/kmer_front.sv]
// Front end: throttles snapshots, counts keys down, classifies edges and keeps
// the held-key and auto-repeat state. Depends on kmer_pkg.
`default_nettype none

module kmer_front #(
    parameter int ROWS = kmer_pkg::ROWS_DEF,
    parameter int COLS = kmer_pkg::COLS_DEF
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire kmer_pkg::t_cfg                          i_cfg,
    input  wire logic                                    i_valid,
    output logic                                         o_ready,
    input  wire logic [kmer_pkg::KEY_W-1:0]              i_snapshot,
    input  wire logic [kmer_pkg::TIME_W-1:0]             i_now,
    output logic                                         o_push,
    output logic [kmer_pkg::job_w(ROWS, COLS)-1:0]       o_job,
    input  wire logic                                    i_full
);
    import kmer_pkg::*;

    localparam int NC    = ROWS * COLS;
    localparam int RW    = idx_w(ROWS);
    localparam int CW    = idx_w(COLS);
    localparam int RC_W  = $clog2(COLS + 1);
    localparam int COMBO_P = COLS;
    localparam int CHORD_P = 3 * COLS + 1;

    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_COUNT = 2'd1;
    localparam logic [1:0] F_CLASS = 2'd2;

    logic [1:0]        r_state;
    logic [NC-1:0]     r_fresh;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_last;
    logic [NC-1:0]     r_held;
    logic              r_rep_act;
    logic [RW-1:0]     r_rep_row;
    logic [CW-1:0]     r_rep_col;
    logic [TIME_W-1:0] r_rep_dl;
    logic [RC_W-1:0]   r_rowcnt [ROWS];

    logic              n_rep_act;
    logic [RW-1:0]     n_rep_row;
    logic [CW-1:0]     n_rep_col;
    logic [TIME_W-1:0] n_rep_dl;

    logic [NC-1:0]     snap_in;
    logic [NC-1:0]     present;
    logic [NC-1:0]     rpt_en;
    logic [NC-1:0]     rel_en;
    logic [NC-1:0]     combo_bit;
    logic              chord;

    logic [TIME_W-1:0] elapsed;
    logic              pass;
    logic [LIMIT_W-1:0] sum;
    logic              ghost;
    logic [NC-1:0]     rising;
    logic [NC-1:0]     falling;
    logic              combo_hit;
    logic [NC-1:0]     p_mask;
    logic [NC-1:0]     r_mask;
    logic [NC-1:0]     cand;
    logic              cand_any;
    logic [RW-1:0]     cand_row;
    logic [CW-1:0]     cand_col;
    logic [COLS-1:0]   cand_slice;
    logic [COLS-1:0]   held_slice;
    logic              key_held;
    logic              due;
    logic [TIME_W-1:0] since_dl;
    logic              any_ev;
    logic              commit;

    // Positions beyond the 56-bit masks do not exist and read as zero.
    for (genvar p = 0; p < NC; p++) begin : g_map
        if (p < KEY_W) begin : g_real
            assign snap_in[p] = i_snapshot[p];
            assign present[p] = i_cfg.present_mask[p];
            assign rpt_en[p]  = i_cfg.repeat_mask[p];
            assign rel_en[p]  = i_cfg.release_mask[p];
        end else begin : g_none
            assign snap_in[p] = 1'b0;
            assign present[p] = 1'b0;
            assign rpt_en[p]  = 1'b0;
            assign rel_en[p]  = 1'b0;
        end
    end

    if (ROWS >= 4 && COLS >= 2 && CHORD_P < KEY_W) begin : g_chord
        assign chord = r_fresh[CHORD_P];
    end else begin : g_nochord
        assign chord = 1'b0;
    end

    if (ROWS >= 2) begin : g_combo
        assign combo_hit = rising[COMBO_P] && chord;
        always_comb begin
            combo_bit          = '0;
            combo_bit[COMBO_P] = combo_hit;
        end
    end else begin : g_nocombo
        assign combo_hit = 1'b0;
        assign combo_bit = '0;
    end

    assign o_ready = (r_state == F_IDLE);
    assign elapsed = i_now - r_last;
    assign pass    = (elapsed >= TIME_W'(i_cfg.scan_interval));

    always_comb begin
        sum = '0;
        for (int r = 0; r < ROWS; r++) begin
            sum = sum + LIMIT_W'(r_rowcnt[r]);
        end
    end

    assign ghost   = (sum > i_cfg.ghost_limit);
    assign rising  = r_fresh & ~r_held;
    assign falling = r_held & ~r_fresh;
    assign p_mask  = ghost ? '0 : ((rising & present) | combo_bit);
    assign r_mask  = (ghost ? r_held : falling) & present & rel_en;
    assign cand    = rising & present & rpt_en & ~combo_bit;
    assign cand_any = |cand;

    // The last repeating press in scan order wins.
    always_comb begin
        cand_row   = '0;
        cand_col   = '0;
        cand_slice = '0;
        held_slice = '0;
        for (int r = 0; r < ROWS; r++) begin
            if (|cand[r*COLS +: COLS]) begin
                cand_row = RW'(r);
            end
        end
        for (int r = 0; r < ROWS; r++) begin
            if (RW'(r) == cand_row) begin
                cand_slice = cand[r*COLS +: COLS];
            end
            if (RW'(r) == r_rep_row) begin
                held_slice = r_fresh[r*COLS +: COLS];
            end
        end
        for (int c = 0; c < COLS; c++) begin
            if (cand_slice[c]) begin
                cand_col = CW'(c);
            end
        end
    end

    assign key_held = held_slice[r_rep_col];
    assign since_dl = r_now - r_rep_dl;

    // A fresh repeat key is due at once only when the delay is zero.
    always_comb begin
        n_rep_act = r_rep_act;
        n_rep_row = r_rep_row;
        n_rep_col = r_rep_col;
        n_rep_dl  = r_rep_dl;
        due       = 1'b0;
        if (ghost) begin
            n_rep_act = 1'b0;
            n_rep_row = '0;
            n_rep_col = '0;
        end else if (cand_any) begin
            n_rep_act = 1'b1;
            n_rep_row = cand_row;
            n_rep_col = cand_col;
            due       = (i_cfg.repeat_delay == '0);
            n_rep_dl  = r_now + TIME_W'(i_cfg.repeat_delay);
        end else if (r_rep_act && !key_held) begin
            n_rep_act = 1'b0;
            n_rep_row = '0;
            n_rep_col = '0;
        end else if (r_rep_act) begin
            due = !since_dl[TIME_W-1];
        end
        if (due) begin
            n_rep_dl = r_now + TIME_W'(i_cfg.repeat_period);
        end
    end

    assign any_ev = (|p_mask) || (|r_mask) || due;
    assign commit = (r_state == F_CLASS) && (!any_ev || !i_full);
    assign o_push = (r_state == F_CLASS) && any_ev && !i_full;
    assign o_job  = {combo_hit && !ghost, due, n_rep_row, n_rep_col, r_mask, p_mask};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_IDLE;
            r_last    <= '0;
            r_held    <= '0;
            r_rep_act <= 1'b0;
            r_rep_row <= '0;
            r_rep_col <= '0;
            r_rep_dl  <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_valid && pass) begin
                        r_last  <= i_now;
                        r_state <= F_COUNT;
                    end
                end
                F_COUNT: begin
                    r_state <= F_CLASS;
                end
                F_CLASS: begin
                    if (commit) begin
                        r_held    <= ghost ? '0 : r_fresh;
                        r_rep_act <= n_rep_act;
                        r_rep_row <= n_rep_row;
                        r_rep_col <= n_rep_col;
                        r_rep_dl  <= n_rep_dl;
                        r_state   <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE) begin
            r_fresh <= snap_in;
            r_now   <= i_now;
        end
        if (r_state == F_COUNT) begin
            for (int r = 0; r < ROWS; r++) begin
                r_rowcnt[r] <= RC_W'($countones(r_fresh[r*COLS +: COLS]));
            end
        end
    end

endmodule

`default_nettype wire

[sv/kmer_back.sv]
// Back end: takes jobs from the queue and sends their events one per cycle
// when not stalled, through a registered output stage. Depends on kmer_pkg.
`default_nettype none

module kmer_back #(
    parameter int ROWS = kmer_pkg::ROWS_DEF,
    parameter int COLS = kmer_pkg::COLS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_empty,
    input  wire logic [kmer_pkg::job_w(ROWS, COLS)-1:0] i_job,
    output logic                                    o_pop,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output kmer_pkg::t_event                        o_event
);
    import kmer_pkg::*;

    localparam int NC    = ROWS * COLS;
    localparam int RW    = idx_w(ROWS);
    localparam int CW    = idx_w(COLS);
    localparam int CNT_W = $clog2(MAX_EVENTS);

    logic             r_busy;
    logic [NC-1:0]    r_p;
    logic [NC-1:0]    r_r;
    logic [CW-1:0]    r_rcol;
    logic [RW-1:0]    r_rrow;
    logic             r_rep;
    logic             r_combo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovalid;
    t_event           r_ev;

    logic [NC-1:0]    n_p;
    logic [NC-1:0]    n_r;
    logic             n_rep;
    t_event           n_ev;

    logic [NC-1:0]    rem;
    logic [ROWS-1:0]  row_any;
    logic [RW-1:0]    sel_row;
    logic [COLS-1:0]  ps;
    logic [COLS-1:0]  rs;
    logic             use_p;
    logic [COLS-1:0]  slice;
    logic [CW-1:0]    sel_col;
    logic             out_free;
    logic             emit;
    logic             more;
    logic             at_cap;

    assign rem      = r_p | r_r;
    assign out_free = !r_ovalid || i_ready;
    assign emit     = r_busy && out_free;
    assign o_pop    = !r_busy && !i_empty;
    assign o_valid  = r_ovalid;
    assign o_event  = r_ev;

    // First row with work left, then presses before releases in that row.
    always_comb begin
        sel_row = '0;
        ps      = '0;
        rs      = '0;
        sel_col = '0;
        for (int r = 0; r < ROWS; r++) begin
            row_any[r] = |rem[r*COLS +: COLS];
        end
        for (int r = ROWS - 1; r >= 0; r--) begin
            if (row_any[r]) begin
                sel_row = RW'(r);
            end
        end
        for (int r = 0; r < ROWS; r++) begin
            if (RW'(r) == sel_row) begin
                ps = r_p[r*COLS +: COLS];
                rs = r_r[r*COLS +: COLS];
            end
        end
        use_p = |ps;
        slice = use_p ? ps : rs;
        for (int c = COLS - 1; c >= 0; c--) begin
            if (slice[c]) begin
                sel_col = CW'(c);
            end
        end
    end

    always_comb begin
        n_p   = r_p;
        n_r   = r_r;
        n_rep = r_rep;
        n_ev  = '0;
        if (|row_any) begin
            for (int r = 0; r < ROWS; r++) begin
                if (RW'(r) == sel_row) begin
                    if (use_p) begin
                        n_p[r*COLS +: COLS] = ps & ~(COLS'(1) << sel_col);
                    end else begin
                        n_r[r*COLS +: COLS] = rs & ~(COLS'(1) << sel_col);
                    end
                end
            end
            n_ev.key_row  = 2'(sel_row);
            n_ev.key_col  = 4'(sel_col);
            n_ev.is_down  = use_p;
            n_ev.is_combo = use_p && r_combo && (sel_row == RW'(1)) && (sel_col == '0);
        end else begin
            n_rep          = 1'b0;
            n_ev.key_row   = 2'(r_rrow);
            n_ev.key_col   = 4'(r_rcol);
            n_ev.is_down   = 1'b1;
            n_ev.is_repeat = 1'b1;
        end
        more      = (|(n_p | n_r)) || n_rep;
        at_cap    = (r_cnt == CNT_W'(MAX_EVENTS - 1));
        n_ev.last = !more || at_cap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (emit && n_ev.last) begin
                r_busy <= 1'b0;
            end
            if (out_free) begin
                r_ovalid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            {r_combo, r_rep, r_rrow, r_rcol, r_r, r_p} <= i_job;
            r_cnt <= '0;
        end else if (emit) begin
            r_p   <= n_p;
            r_r   <= n_r;
            r_rep <= n_rep;
            r_cnt <= r_cnt + 1'b1;
        end
        if (emit) begin
            r_ev <= n_ev;
        end
    end

endmodule

`default_nettype wire
